### src/phfl_pkg.sv
// ---------------------------------------------------------------------------
// phfl_pkg - shared types and constants
// Position width, status codes and the byte class token passed from the
// classifier front end to the header scanner.
// ---------------------------------------------------------------------------
package phfl_pkg;

    localparam int POS_BITS = 16;
    localparam logic [POS_BITS-1:0] POS_MAX = {POS_BITS{1'b1}};

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);

    localparam logic [7:0] CH_DASH  = 8'h2D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_NL    = 8'h0A;
    localparam logic [7:0] CH_NUL   = 8'h00;

    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_NO_SEP   = 3'd1;
    localparam logic [2:0] ST_NO_TITLE = 3'd2;
    localparam logic [2:0] ST_NO_TIME  = 3'd3;
    localparam logic [2:0] ST_NO_TAG   = 3'd4;
    localparam logic [2:0] ST_TOO_LONG = 3'd5;

    // one classified byte
    typedef struct packed {
        logic last;
        logic nul;
        logic nl;
        logic dash;
        logic blank;
    } t_tok;

endpackage

### src/phfl_front.sv
// ---------------------------------------------------------------------------
// phfl_front - input classifier
// Accepts one byte per cycle while the queue takes its tokens, and registers its class token.
// ---------------------------------------------------------------------------
module phfl_front
    import phfl_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic [7:0] i_data_byte,
    input  logic       i_last,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    output logic       o_tok_valid,
    output t_tok       o_tok,
    input  logic       i_tok_ready
);

    logic r_valid;
    t_tok r_tok;
    t_tok n_tok;

    always_comb begin
        n_tok.last  = i_last;
        n_tok.nul   = (i_data_byte == CH_NUL);
        n_tok.nl    = (i_data_byte == CH_NL);
        n_tok.dash  = (i_data_byte == CH_DASH);
        n_tok.blank = (i_data_byte == CH_SPACE) || (i_data_byte == CH_TAB);
    end

    assign o_in_ready  = !r_valid || i_tok_ready;
    assign o_tok_valid = r_valid;
    assign o_tok       = r_tok;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_tok <= n_tok;
        end
    end

endmodule

### src/phfl_queue.sv
// ---------------------------------------------------------------------------
// phfl_queue - token queue
// Small FIFO between classifier and scanner so each side stalls alone.
// ---------------------------------------------------------------------------
module phfl_queue
    import phfl_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push_valid,
    output logic o_push_ready,
    input  t_tok i_push_tok,
    output logic o_pop_valid,
    input  logic i_pop_ready,
    output t_tok o_pop_tok
);

    t_tok                 r_mem [QUEUE_DEPTH];
    logic [QPTR_BITS-1:0] r_wr;
    logic [QPTR_BITS-1:0] r_rd;
    logic [QPTR_BITS:0]   r_count;
    logic                 push;
    logic                 pop;

    assign o_push_ready = (r_count != QUEUE_DEPTH[QPTR_BITS:0]);
    assign o_pop_valid  = (r_count != '0);
    assign o_pop_tok    = r_mem[r_rd];
    assign push         = i_push_valid && o_push_ready;
    assign pop          = o_pop_valid && i_pop_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (pop) begin
                r_rd <= r_rd + 1'b1;
            end
            if (push && !pop) begin
                r_count <= r_count + 1'b1;
            end else if (pop && !push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr] <= i_push_tok;
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= QUEUE_DEPTH[QPTR_BITS:0])
        else $error("queue count above depth");
    a_count_up: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push && !pop |=> r_count == $past(r_count) + 1'b1)
        else $error("queue count not incremented");
    a_ptr_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count[QPTR_BITS-1:0] == QPTR_BITS'(r_wr - r_rd))
        else $error("queue pointers disagree with count");

endmodule

### src/phfl_back.sv
// ---------------------------------------------------------------------------
// phfl_back - header scanner
// Tracks lines, separator match and field positions; registers the result
// on the last byte and clears its state for the next document.
// ---------------------------------------------------------------------------
module phfl_back
    import phfl_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_tok_valid,
    output logic                o_tok_ready,
    input  t_tok                i_tok,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output logic [2:0]          o_status,
    output logic [POS_BITS-1:0] o_title_start,
    output logic [POS_BITS-1:0] o_title_len,
    output logic [POS_BITS-1:0] o_time_start,
    output logic [POS_BITS-1:0] o_time_len,
    output logic [POS_BITS-1:0] o_tag_start,
    output logic [POS_BITS-1:0] o_tag_len,
    output logic [POS_BITS-1:0] o_body_start
);

    localparam logic [2:0] M_LEAD   = 3'd0;
    localparam logic [2:0] M_D1     = 3'd1;
    localparam logic [2:0] M_D2     = 3'd2;
    localparam logic [2:0] M_DASHES = 3'd3;
    localparam logic [2:0] M_TRAIL  = 3'd4;
    localparam logic [2:0] M_FAIL   = 3'd5;

    function automatic logic [2:0] next_match(input logic [2:0] s, input t_tok t);
        logic [2:0] r;
        case (s)
            M_LEAD:   r = t.blank ? M_LEAD : (t.dash ? M_D1 : M_FAIL);
            M_D1:     r = t.dash ? M_D2 : M_FAIL;
            M_D2:     r = t.dash ? M_DASHES : M_FAIL;
            M_DASHES: r = t.dash ? M_DASHES : (t.blank ? M_TRAIL : M_FAIL);
            M_TRAIL:  r = t.blank ? M_TRAIL : M_FAIL;
            default:  r = M_FAIL;
        endcase
        return r;
    endfunction

    logic [POS_BITS-1:0] r_pos, n_pos;
    logic                r_ended, n_ended;
    logic                r_ovf, n_ovf;
    logic [2:0]          r_match, n_match;
    logic                r_has, n_has;
    logic [POS_BITS-1:0] r_first, n_first;
    logic [POS_BITS-1:0] r_lastp, n_lastp;
    logic [1:0]          r_found, n_found;
    logic                r_sep, n_sep;
    logic                r_body_loc, n_body_loc;
    logic [POS_BITS-1:0] r_body_pos, n_body_pos;
    logic [POS_BITS-1:0] r_starts [3];
    logic [POS_BITS-1:0] n_starts [3];
    logic [POS_BITS-1:0] r_lens [3];
    logic [POS_BITS-1:0] n_lens [3];

    logic                r_out_valid;
    logic [2:0]          r_status, n_status;
    logic [POS_BITS-1:0] r_res [7];
    logic [POS_BITS-1:0] n_res [7];
    logic                sep_final;
    logic                keep;
    logic                pop;

    always_comb begin
        n_pos      = r_pos;
        n_ended    = r_ended;
        n_ovf      = r_ovf;
        n_match    = r_match;
        n_has      = r_has;
        n_first    = r_first;
        n_lastp    = r_lastp;
        n_found    = r_found;
        n_sep      = r_sep;
        n_body_loc = r_body_loc;
        n_body_pos = r_body_pos;
        n_starts   = r_starts;
        n_lens     = r_lens;
        if (!r_ended && !r_ovf) begin
            if (i_tok.nul) begin
                n_ended = 1'b1;
            end else if (r_pos == POS_MAX) begin
                n_ovf = 1'b1;
            end else begin
                n_pos = r_pos + 1'b1;
                if (r_sep) begin
                    if (!r_body_loc && !i_tok.blank && !i_tok.nl) begin
                        n_body_pos = r_pos;
                        n_body_loc = 1'b1;
                    end
                end else if (i_tok.nl) begin
                    if (r_match == M_DASHES || r_match == M_TRAIL) begin
                        n_sep = 1'b1;
                    end else if (r_has && r_found != 2'd3) begin
                        n_starts[r_found] = r_first;
                        n_lens[r_found]   = r_lastp - r_first + 1'b1;
                        n_found           = r_found + 1'b1;
                    end
                    n_match = M_LEAD;
                    n_has   = 1'b0;
                    n_first = '0;
                    n_lastp = '0;
                end else begin
                    n_match = next_match(r_match, i_tok);
                    if (!i_tok.blank) begin
                        if (!r_has) begin
                            n_first = r_pos;
                        end
                        n_lastp = r_pos;
                        n_has   = 1'b1;
                    end
                end
            end
        end
    end

    // result as seen after this byte
    always_comb begin
        sep_final = n_sep || (!n_ovf && (n_match == M_DASHES || n_match == M_TRAIL));
        keep      = !n_ovf && sep_final;
        if (n_ovf) begin
            n_status = ST_TOO_LONG;
        end else if (!sep_final) begin
            n_status = ST_NO_SEP;
        end else if (n_found == 2'd3) begin
            n_status = ST_OK;
        end else begin
            n_status = {1'b0, n_found} + ST_NO_TITLE;
        end
        for (int k = 0; k < 3; k++) begin
            n_res[2*k]   = keep ? n_starts[k] : '0;
            n_res[2*k+1] = keep ? n_lens[k] : '0;
        end
        n_res[6] = keep ? (n_body_loc ? n_body_pos : n_pos) : '0;
    end

    assign o_tok_ready = !i_tok.last || !r_out_valid || i_out_ready;
    assign pop         = i_tok_valid && o_tok_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (pop && i_tok.last)) begin
            r_pos      <= '0;
            r_ended    <= 1'b0;
            r_ovf      <= 1'b0;
            r_match    <= M_LEAD;
            r_has      <= 1'b0;
            r_first    <= '0;
            r_lastp    <= '0;
            r_found    <= '0;
            r_sep      <= 1'b0;
            r_body_loc <= 1'b0;
            r_body_pos <= '0;
            for (int k = 0; k < 3; k++) begin
                r_starts[k] <= '0;
                r_lens[k]   <= '0;
            end
        end else if (pop) begin
            r_pos      <= n_pos;
            r_ended    <= n_ended;
            r_ovf      <= n_ovf;
            r_match    <= n_match;
            r_has      <= n_has;
            r_first    <= n_first;
            r_lastp    <= n_lastp;
            r_found    <= n_found;
            r_sep      <= n_sep;
            r_body_loc <= n_body_loc;
            r_body_pos <= n_body_pos;
            r_starts   <= n_starts;
            r_lens     <= n_lens;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (pop && i_tok.last) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (pop && i_tok.last) begin
            r_status <= n_status;
            r_res    <= n_res;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_status      = r_status;
    assign o_title_start = r_res[0];
    assign o_title_len   = r_res[1];
    assign o_time_start  = r_res[2];
    assign o_time_len    = r_res[3];
    assign o_tag_start   = r_res[4];
    assign o_tag_len     = r_res[5];
    assign o_body_start  = r_res[6];

    a_clear_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pop && i_tok.last |=> r_pos == '0 && !r_sep && r_found == '0)
        else $error("state not cleared after last byte");
    a_ovf_at_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovf |-> r_pos == POS_MAX)
        else $error("overflow flag without full position");
    a_body_after_sep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_body_loc |-> r_sep)
        else $error("body located before separator");
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |-> !(pop && i_tok.last))
        else $error("pending result overwritten");

endmodule

### src/post_header_field_locator.sv
// Result path of the last byte: classifier token register, queue write, then the
//   scanner result register, which raises result valid; a stall can hold it between them.
// Throughput: one byte per cycle while nothing stalls; the scanner updates its line state per byte.
// A pending result stalls only the last byte of the next document.
// Reset: synchronous, active low; clears queue, scanner state and result valid.
// ---------------------------------------------------------------------------
// post_header_field_locator - header field and body locator
// Scans a byte stream for title, time and tag lines before a dashed
// separator line and reports their offsets, lengths and the body start.
// ---------------------------------------------------------------------------
module post_header_field_locator
    import phfl_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  logic [7:0]          i_data_byte,
    input  logic                i_last,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output logic [2:0]          o_status,
    output logic [POS_BITS-1:0] o_title_start,
    output logic [POS_BITS-1:0] o_title_len,
    output logic [POS_BITS-1:0] o_time_start,
    output logic [POS_BITS-1:0] o_time_len,
    output logic [POS_BITS-1:0] o_tag_start,
    output logic [POS_BITS-1:0] o_tag_len,
    output logic [POS_BITS-1:0] o_body_start
);

    logic f_valid;
    logic f_ready;
    t_tok f_tok;
    logic q_valid;
    logic q_ready;
    t_tok q_tok;

    phfl_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_data_byte (i_data_byte),
        .i_last      (i_last),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_tok_valid (f_valid),
        .o_tok       (f_tok),
        .i_tok_ready (f_ready)
    );

    phfl_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (f_valid),
        .o_push_ready (f_ready),
        .i_push_tok   (f_tok),
        .o_pop_valid  (q_valid),
        .i_pop_ready  (q_ready),
        .o_pop_tok    (q_tok)
    );

    phfl_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_tok_valid   (q_valid),
        .o_tok_ready   (q_ready),
        .i_tok         (q_tok),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_status      (o_status),
        .o_title_start (o_title_start),
        .o_title_len   (o_title_len),
        .o_time_start  (o_time_start),
        .o_time_len    (o_time_len),
        .o_tag_start   (o_tag_start),
        .o_tag_len     (o_tag_len),
        .o_body_start  (o_body_start)
    );

endmodule

### dv/phfl_checker.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// phfl_checker - header locator scoreboard
// Watches both channels of the header field locator, runs its own scan of
// every accepted byte, and compares each accepted result field by field.
// ---------------------------------------------------------------------------
module phfl_checker
    import phfl_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  logic                i_in_ready,
    input  logic [7:0]          i_data_byte,
    input  logic                i_last,
    input  logic                i_out_valid,
    input  logic                i_out_ready,
    input  logic [2:0]          i_status,
    input  logic [POS_BITS-1:0] i_title_start,
    input  logic [POS_BITS-1:0] i_title_len,
    input  logic [POS_BITS-1:0] i_time_start,
    input  logic [POS_BITS-1:0] i_time_len,
    input  logic [POS_BITS-1:0] i_tag_start,
    input  logic [POS_BITS-1:0] i_tag_len,
    input  logic [POS_BITS-1:0] i_body_start,
    output int                  o_fail_count,
    output int                  o_pending
);

    // progress of the current line toward a dashed separator
    typedef enum logic [2:0] {
        LM_LEAD,
        LM_D1,
        LM_D2,
        LM_DASHES,
        LM_TRAIL,
        LM_FAIL
    } t_line_match;

    typedef struct packed {
        logic [2:0]          status;
        logic [POS_BITS-1:0] title_start;
        logic [POS_BITS-1:0] title_len;
        logic [POS_BITS-1:0] time_start;
        logic [POS_BITS-1:0] time_len;
        logic [POS_BITS-1:0] tag_start;
        logic [POS_BITS-1:0] tag_len;
        logic [POS_BITS-1:0] body_start;
    } t_layout;

    t_layout             header_layouts_q[$];
    t_layout             want;
    int                  errors = 0;

    logic [POS_BITS-1:0] byte_pos;
    logic                text_done;
    logic                too_long;
    t_line_match         line_st;
    logic                line_busy;
    logic [POS_BITS-1:0] line_first;
    logic [POS_BITS-1:0] line_last;
    int unsigned         n_fields;
    logic                sep_found;
    logic                body_found;
    logic [POS_BITS-1:0] fld_start [3];
    logic [POS_BITS-1:0] fld_len [3];
    logic [POS_BITS-1:0] body_pos;

    assign o_fail_count = errors;

    function automatic logic is_blank(logic [7:0] c);
        return c == CH_SPACE || c == CH_TAB;
    endfunction

    function automatic t_line_match next_line_match(t_line_match s, logic [7:0] c);
        logic dash;
        dash = (c == CH_DASH);
        case (s)
            LM_LEAD:   return is_blank(c) ? LM_LEAD : (dash ? LM_D1 : LM_FAIL);
            LM_D1:     return dash ? LM_D2 : LM_FAIL;
            LM_D2:     return dash ? LM_DASHES : LM_FAIL;
            LM_DASHES: return dash ? LM_DASHES : (is_blank(c) ? LM_TRAIL : LM_FAIL);
            LM_TRAIL:  return is_blank(c) ? LM_TRAIL : LM_FAIL;
            default:   return LM_FAIL;
        endcase
    endfunction

    task automatic clear_scan();
        byte_pos   = '0;
        text_done  = 1'b0;
        too_long   = 1'b0;
        line_st    = LM_LEAD;
        line_busy  = 1'b0;
        line_first = '0;
        line_last  = '0;
        n_fields   = 0;
        sep_found  = 1'b0;
        body_found = 1'b0;
        body_pos   = '0;
        for (int i = 0; i < 3; i++) begin
            fld_start[i] = '0;
            fld_len[i]   = '0;
        end
    endtask

    task automatic scan_text_byte(logic [7:0] c);
        if (sep_found) begin
            if (!body_found && !is_blank(c) && c != CH_NL) begin
                body_pos   = byte_pos;
                body_found = 1'b1;
            end
        end else if (c == CH_NL) begin
            if (line_st == LM_DASHES || line_st == LM_TRAIL) begin
                sep_found = 1'b1;
            end else if (line_busy && n_fields < 3) begin
                fld_start[n_fields] = line_first;
                fld_len[n_fields]   = line_last - line_first + 1'b1;
                n_fields++;
            end
            line_st    = LM_LEAD;
            line_busy  = 1'b0;
            line_first = '0;
            line_last  = '0;
        end else begin
            line_st = next_line_match(line_st, c);
            if (!is_blank(c)) begin
                if (!line_busy)
                    line_first = byte_pos;
                line_last = byte_pos;
                line_busy = 1'b1;
            end
        end
    endtask

    task automatic take_doc_byte(logic [7:0] c, logic is_last);
        t_layout r;
        if (!text_done && !too_long) begin
            if (c == CH_NUL) begin
                text_done = 1'b1;
            end else if (byte_pos == POS_MAX) begin
                too_long = 1'b1;
            end else begin
                scan_text_byte(c);
                byte_pos = byte_pos + 1'b1;
            end
        end
        if (is_last) begin
            // a separator line may also be closed by the end of the text
            if (!sep_found && !too_long && (line_st == LM_DASHES || line_st == LM_TRAIL))
                sep_found = 1'b1;
            r = '0;
            if (too_long) begin
                r.status = ST_TOO_LONG;
            end else if (!sep_found) begin
                r.status = ST_NO_SEP;
            end else begin
                case (n_fields)
                    0:       r.status = ST_NO_TITLE;
                    1:       r.status = ST_NO_TIME;
                    2:       r.status = ST_NO_TAG;
                    default: r.status = ST_OK;
                endcase
                if (n_fields > 0) begin
                    r.title_start = fld_start[0];
                    r.title_len   = fld_len[0];
                end
                if (n_fields > 1) begin
                    r.time_start = fld_start[1];
                    r.time_len   = fld_len[1];
                end
                if (n_fields > 2) begin
                    r.tag_start = fld_start[2];
                    r.tag_len   = fld_len[2];
                end
                r.body_start = body_found ? body_pos : byte_pos;
            end
            header_layouts_q.push_back(r);
            clear_scan();
        end
    endtask

    task automatic check_field(string name, logic [POS_BITS-1:0] exp_v,
                               logic [POS_BITS-1:0] act_v);
        if (exp_v !== act_v) begin
            $error("%s: expected %0d, got %0d", name, exp_v, act_v);
            errors++;
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            clear_scan();
            header_layouts_q.delete();
        end else begin
            if (i_out_valid && i_out_ready) begin
                if (header_layouts_q.size() == 0) begin
                    $error("result transfer with no result predicted");
                    errors++;
                end else begin
                    want = header_layouts_q.pop_front();
                    check_field("status", POS_BITS'(want.status), POS_BITS'(i_status));
                    check_field("title_start", want.title_start, i_title_start);
                    check_field("title_len", want.title_len, i_title_len);
                    check_field("time_start", want.time_start, i_time_start);
                    check_field("time_len", want.time_len, i_time_len);
                    check_field("tag_start", want.tag_start, i_tag_start);
                    check_field("tag_len", want.tag_len, i_tag_len);
                    check_field("body_start", want.body_start, i_body_start);
                end
            end
            if (i_in_valid && i_in_ready)
                take_doc_byte(i_data_byte, i_last);
        end
        o_pending <= header_layouts_q.size();
    end

endmodule

### dv/tb_top.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_top - header field locator testbench
// Streams directed and random documents through the locator under several
// idle and stall mixes; the checker scores every result.
// ---------------------------------------------------------------------------
module tb_top
    import phfl_pkg::*;
();

    localparam int QUIET_LIMIT  = 5000;
    localparam int SETTLE_TICKS = 8;

    logic                i_clk;
    logic                i_rst_n;
    logic                i_in_valid;
    logic                o_in_ready;
    logic [7:0]          i_data_byte;
    logic                i_last;
    logic                o_out_valid;
    logic                i_out_ready = 1'b0;
    logic [2:0]          o_status;
    logic [POS_BITS-1:0] o_title_start;
    logic [POS_BITS-1:0] o_title_len;
    logic [POS_BITS-1:0] o_time_start;
    logic [POS_BITS-1:0] o_time_len;
    logic [POS_BITS-1:0] o_tag_start;
    logic [POS_BITS-1:0] o_tag_len;
    logic [POS_BITS-1:0] o_body_start;

    int                  fail_count;
    int                  pending;
    int unsigned         idle_pct  = 0;
    int unsigned         stall_pct = 0;
    int unsigned         quiet_cycles = 0;
    logic [7:0]          doc_bytes[$];

    post_header_field_locator i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_data_byte   (i_data_byte),
        .i_last        (i_last),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_status      (o_status),
        .o_title_start (o_title_start),
        .o_title_len   (o_title_len),
        .o_time_start  (o_time_start),
        .o_time_len    (o_time_len),
        .o_tag_start   (o_tag_start),
        .o_tag_len     (o_tag_len),
        .o_body_start  (o_body_start)
    );

    phfl_checker i_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .i_in_ready    (o_in_ready),
        .i_data_byte   (i_data_byte),
        .i_last        (i_last),
        .i_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .i_status      (o_status),
        .i_title_start (o_title_start),
        .i_title_len   (o_title_len),
        .i_time_start  (o_time_start),
        .i_time_len    (o_time_len),
        .i_tag_start   (o_tag_start),
        .i_tag_len     (o_tag_len),
        .i_body_start  (o_body_start),
        .o_fail_count  (fail_count),
        .o_pending     (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        i_out_ready <= ($urandom_range(99) >= stall_pct);
    end

    // ends the run when neither channel has moved for too long
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("tb_top: errors");
                $finish;
            end
        end
    end

    function automatic logic [7:0] text_char();
        case ($urandom_range(11))
            0:       return CH_DASH;
            1:       return CH_SPACE;
            2:       return CH_TAB;
            3, 4:    return 8'($urandom_range(255, 1));
            default: return 8'($urandom_range(8'h7E, 8'h21));
        endcase
    endfunction

    task automatic load_text(string s);
        for (int i = 0; i < s.len(); i++)
            doc_bytes.push_back(s[i]);
    endtask

    task automatic push_blanks(int unsigned max_n);
        repeat ($urandom_range(max_n))
            doc_bytes.push_back($urandom_range(1) ? CH_SPACE : CH_TAB);
    endtask

    // lines that must not be taken for a separator; a blank-only one is no field either
    task automatic push_filler_line();
        case ($urandom_range(2))
            0: push_blanks(3);
            1: begin
                push_blanks(2);
                repeat ($urandom_range(2, 1)) doc_bytes.push_back(CH_DASH);
                push_blanks(2);
            end
            default: begin
                push_blanks(1);
                repeat ($urandom_range(5, 3)) doc_bytes.push_back(CH_DASH);
                push_blanks(1);
                doc_bytes.push_back(8'($urandom_range(8'h7A, 8'h61)));
            end
        endcase
        doc_bytes.push_back(CH_NL);
    endtask

    task automatic build_random_doc();
        int unsigned n_content;
        int unsigned fillers;
        doc_bytes.delete();
        if ($urandom_range(99) < 12) begin
            repeat ($urandom_range(30, 1)) begin
                case ($urandom_range(3))
                    0:       doc_bytes.push_back(CH_NL);
                    1:       doc_bytes.push_back(CH_DASH);
                    default: doc_bytes.push_back(8'($urandom_range(255, 1)));
                endcase
            end
        end else begin
            n_content = ($urandom_range(3) != 0) ? 3 : $urandom_range(4);
            fillers   = $urandom_range(2);
            while (n_content + fillers > 0) begin
                if (fillers > 0 && (n_content == 0 || $urandom_range(3) == 0)) begin
                    push_filler_line();
                    fillers--;
                end else begin
                    push_blanks(2);
                    doc_bytes.push_back(8'($urandom_range(8'h7E, 8'h21)));
                    repeat ($urandom_range(7)) doc_bytes.push_back(text_char());
                    push_blanks(2);
                    doc_bytes.push_back(CH_NL);
                    n_content--;
                end
            end
            if ($urandom_range(9) != 0) begin
                push_blanks(2);
                repeat ($urandom_range(6, 3)) doc_bytes.push_back(CH_DASH);
                push_blanks(2);
                if ($urandom_range(5) != 0) begin
                    doc_bytes.push_back(CH_NL);
                    repeat ($urandom_range(3)) begin
                        case ($urandom_range(2))
                            0:       doc_bytes.push_back(CH_SPACE);
                            1:       doc_bytes.push_back(CH_TAB);
                            default: doc_bytes.push_back(CH_NL);
                        endcase
                    end
                    repeat ($urandom_range(12)) doc_bytes.push_back(text_char());
                end
            end
        end
        // early end of text, followed by bytes that must be ignored
        if ($urandom_range(99) < 8) begin
            doc_bytes.insert($urandom_range(doc_bytes.size()), CH_NUL);
            repeat ($urandom_range(4)) doc_bytes.push_back(8'($urandom_range(255)));
        end
        if (doc_bytes.size() == 0)
            doc_bytes.push_back(text_char());
    endtask

    task automatic send_byte(logic [7:0] b, logic is_last);
        while ($urandom_range(99) < idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_data_byte <= b;
        i_last      <= is_last;
        do @(posedge i_clk); while (!o_in_ready);
    endtask

    task automatic send_doc();
        for (int i = 0; i < doc_bytes.size(); i++)
            send_byte(doc_bytes[i], i == doc_bytes.size() - 1);
    endtask

    task automatic send_text(string s);
        doc_bytes.delete();
        load_text(s);
        send_doc();
    endtask

    // hold the sender until every predicted result has been taken
    task automatic drain();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
        repeat (SETTLE_TICKS) @(posedge i_clk);
    endtask

    initial begin
        int unsigned sent;
        int unsigned docs;
        i_rst_n     <= 1'b0;
        i_in_valid  <= 1'b0;
        i_data_byte <= '0;
        i_last      <= 1'b0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: full header, bare separator, missing tag, no separator
        send_text("Ti\n 9:30\t\n\ttg \n---\n\n b");
        send_text("---");
        send_text("a\n \t\nb\n -----\t\n");
        send_text("x");
        // empty document
        doc_bytes.delete();
        doc_bytes.push_back(CH_NUL);
        send_doc();
        // separator only after the end of text
        doc_bytes.delete();
        load_text("a\n--\n-- -\n");
        doc_bytes.push_back(CH_NUL);
        load_text("---\n");
        doc_bytes.push_back(8'hFF);
        send_doc();
        drain();

        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0:       begin idle_pct = 0;  stall_pct = 0;  end
                1:       begin idle_pct = 65; stall_pct = 0;  end
                2:       begin idle_pct = 0;  stall_pct = 65; end
                default: begin idle_pct = 30; stall_pct = 30; end
            endcase
            sent = 0;
            docs = 0;
            while (sent < 140) begin
                build_random_doc();
                send_doc();
                sent += doc_bytes.size();
                docs++;
                if (phase == 1 && docs == 2)
                    drain();
            end
            drain();
        end

        if (fail_count == 0)
            $display("tb_top: clean");
        else
            $display("tb_top: errors");
        $finish;
    end

endmodule
